// ===== rtl/sld_pkg.sv =====
// sld_pkg: shared types, widths and reset constants of the sta/lta event detector
// depends on nothing; used by sld_mac, sld_core and sta_lta_event_detector_top

package sld_pkg;

    // default tuning values of the top level
    localparam int unsigned BASE_GAIN_DEF      = 328;
    localparam int unsigned SHORT_ALPHA_DEF    = 1311;
    localparam int unsigned LONG_ALPHA_DEF     = 33;
    localparam int unsigned SCALE_DEF          = 256;
    localparam int unsigned ERROR_LIMIT_DEF    = 10;

    // sample status codes
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;

    // config register indexes
    localparam logic [2:0] REG_TRIGGER   = 3'd0;
    localparam logic [2:0] REG_DETRIGGER = 3'd1;
    localparam logic [2:0] REG_MIN_STA   = 3'd2;
    localparam logic [2:0] REG_MIN_LTA   = 3'd3;
    localparam logic [2:0] REG_CONFIRM   = 3'd4;
    localparam logic [2:0] REG_MAX_EVENT = 3'd5;
    localparam logic [2:0] REG_COOLDOWN  = 3'd6;
    localparam logic [2:0] REG_WARMUP    = 3'd7;

    // config reset values
    localparam logic [15:0] RST_TRIGGER   = 16'd768;
    localparam logic [15:0] RST_DETRIGGER = 16'd384;
    localparam logic [23:0] RST_MIN_STA   = 24'd256;
    localparam logic [23:0] RST_MIN_LTA   = 24'd256;
    localparam logic [31:0] RST_CONFIRM   = 32'd1000;
    localparam logic [31:0] RST_MAX_EVENT = 32'd60000;
    localparam logic [31:0] RST_COOLDOWN  = 32'd10000;
    localparam logic [31:0] RST_WARMUP    = 32'd30000;

    // datapath widths
    localparam int unsigned ACC_W = 40;   // multiply-accumulate register
    localparam int unsigned ALU_W = 27;   // shared subtract/compare unit
    localparam logic [15:0] EMA_HALF = 16'h8000;
    localparam logic [23:0] MAX24 = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0] trigger_ratio;
        logic [15:0] detrigger_ratio;
        logic [23:0] min_sta_level;
        logic [23:0] min_lta_level;
        logic [31:0] confirm_ms;
        logic [31:0] max_event_ms;
        logic [31:0] cooldown_ms;
        logic [31:0] warmup_ms;
    } cfg_t;

    typedef struct packed {
        logic        event_active;
        logic        potential_pending;
        logic        event_confirmed;
        logic        report_valid;
        logic [23:0] report_peak;
        logic [31:0] report_duration_ms;
        logic [31:0] report_time_ms;
        logic        fifo_reset;
        logic [23:0] sta_level;
        logic [23:0] lta_level;
        logic [15:0] overflow_count;
    } result_t;

endpackage

// ===== rtl/sld_alu.sv =====
// sld_alu: shared subtract and compare unit, used by the square root and the divider
// depends on nothing

module sld_alu #(
    parameter int unsigned W = 27
) (
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    output logic [W-1:0] diff,
    output logic         ge
);

    logic [W:0] wide;

    // one subtractor, borrow gives the compare
    assign wide = {1'b0, op_a} - {1'b0, op_b};
    assign diff = wide[W-1:0];
    assign ge   = ~wide[W];

endmodule

// ===== rtl/sld_mac.sv =====
// sld_mac: 16x24 multiply-accumulate used for squares, scaling and the averages
// depends on sld_pkg

module sld_mac (
    input  logic [15:0]               mul_x,
    input  logic [23:0]               mul_y,
    input  logic [15:0]               addend,
    input  logic [sld_pkg::ACC_W-1:0] acc_in,
    input  logic                      clr,
    output logic [sld_pkg::ACC_W-1:0] acc_out
);

    logic [39:0] prod;

    assign prod = {24'd0, mul_x} * {16'd0, mul_y};

    // product plus optional running sum and rounding constant
    assign acc_out = (clr ? '0 : acc_in) + sld_pkg::ACC_W'(prod)
                   + sld_pkg::ACC_W'(addend);

endmodule

// ===== rtl/sld_core.sv =====
// sld_core: sequencer and detector state; runs magnitude, averages and ratio
// depends on sld_pkg, sld_alu, sld_mac

module sld_core #(
    parameter logic [15:0] BASE_GAIN      = 16'(sld_pkg::BASE_GAIN_DEF),
    parameter logic [15:0] SHORT_ALPHA    = 16'(sld_pkg::SHORT_ALPHA_DEF),
    parameter logic [15:0] LONG_ALPHA     = 16'(sld_pkg::LONG_ALPHA_DEF),
    parameter logic [15:0] SCALE          = 16'(sld_pkg::SCALE_DEF),
    parameter logic [7:0]  ERROR_LIMIT    = 8'(sld_pkg::ERROR_LIMIT_DEF)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sld_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_status,
    input  logic [15:0]      in_x,
    input  logic [15:0]      in_y,
    input  logic [15:0]      in_z,
    input  logic [31:0]      in_now,
    output logic             res_valid,
    input  logic             res_ready,
    output sld_pkg::result_t res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_EA    = 4'd4;
    localparam logic [3:0] S_EB    = 4'd5;
    localparam logic [3:0] S_EW    = 4'd6;
    localparam logic [3:0] S_GATE  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DET   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [1:0] E_BASE  = 2'd0;
    localparam logic [1:0] E_SHORT = 2'd1;
    localparam logic [1:0] E_LONG  = 2'd2;

    localparam int unsigned AW = sld_pkg::ACC_W;
    localparam int unsigned LW = sld_pkg::ALU_W;

    logic [3:0]  state_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  eidx_reg;

    // per-sample working registers
    logic [15:0] ax_reg, ay_reg, az_reg;
    logic [31:0] now_reg;
    logic [AW-1:0] acc_reg;
    logic [47:0] vsh_reg;
    logic [24:0] rem_reg;
    logic [23:0] root_reg;
    logic [23:0] mag_reg, corr_reg, lc_reg;
    logic [31:0] dvd_reg;

    // detector state
    logic [23:0] baseline_reg, short_reg, long_reg, peak_reg;
    logic        pend_reg, act_reg;
    logic [31:0] since_reg, start_reg, last_reg;
    logic [7:0]  err_reg;
    logic [15:0] ovf_reg;

    // per-sample pulses and report
    logic        conf_reg, rep_reg, fifo_reg;
    logic [23:0] rep_peak_reg;
    logic [31:0] rep_dur_reg, rep_time_reg;

    // shared units
    logic [LW-1:0] alu_a, alu_b, alu_diff;
    logic          alu_ge;
    logic [15:0]   mac_x, mac_add;
    logic [23:0]   mac_y;
    logic          mac_clr;
    logic [AW-1:0] mac_out;

    logic [23:0] mag_sat, new_avg, ema_avg;
    logic [15:0] ema_alpha;
    logic [8:0]  err_inc;

    // detection step results
    logic        above;
    logic        d_pend, d_act, d_conf, d_rep;
    logic [31:0] d_since, d_start, d_dur;
    logic [23:0] d_peak;

    sld_alu #(.W(LW)) u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    sld_mac u_mac (
        .mul_x   (mac_x),
        .mul_y   (mac_y),
        .addend  (mac_add),
        .acc_in  (acc_reg),
        .clr     (mac_clr),
        .acc_out (mac_out)
    );

    // scaled magnitude, saturated to 24 bits
    assign mag_sat = (acc_reg[AW-1:32] != '0) ? sld_pkg::MAX24 : acc_reg[31:8];
    assign new_avg = acc_reg[39:16];
    assign err_inc = {1'b0, err_reg} + 9'd1;

    // alpha and old average of the average being updated
    always_comb begin
        ema_alpha = BASE_GAIN;
        ema_avg   = baseline_reg;
        case (eidx_reg)
            E_SHORT: begin
                ema_alpha = SHORT_ALPHA;
                ema_avg   = short_reg;
            end
            E_LONG: begin
                ema_alpha = LONG_ALPHA;
                ema_avg   = long_reg;
            end
            default: begin
                ema_alpha = BASE_GAIN;
                ema_avg   = baseline_reg;
            end
        endcase
    end

    // operand select for the shared units
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        mac_x   = '0;
        mac_y   = '0;
        mac_add = '0;
        mac_clr = 1'b1;
        unique case (state_reg)
            S_SQ: begin
                mac_clr = (cnt_reg == 5'd0);
                case (cnt_reg[1:0])
                    2'd0:    mac_x = ax_reg;
                    2'd1:    mac_x = ay_reg;
                    default: mac_x = az_reg;
                endcase
                mac_y = {8'd0, mac_x};
            end
            S_SQRT: begin
                alu_a = {rem_reg, vsh_reg[47:46]};
                alu_b = {1'b0, root_reg, 2'b01};
            end
            S_SCALE: begin
                mac_x = SCALE;
                mac_y = root_reg;
            end
            S_EA: begin
                mac_x = ema_alpha;
                mac_y = (eidx_reg == E_BASE) ? mag_sat : corr_reg;
            end
            S_EB: begin
                mac_clr = 1'b0;
                mac_x   = 16'(17'h10000 - {1'b0, ema_alpha});
                mac_y   = ema_avg;
                mac_add = sld_pkg::EMA_HALF;
            end
            S_DIV: begin
                alu_a = {2'b00, rem_reg[23:0], dvd_reg[31]};
                alu_b = {3'b000, lc_reg};
            end
            default: begin
                mac_clr = 1'b1;
            end
        endcase
    end

    // trigger, confirmation and end of event, in that order
    always_comb begin
        above   = (dvd_reg >= {16'd0, cfg.trigger_ratio})
                  && (short_reg >= cfg.min_sta_level);
        d_pend  = pend_reg;
        d_act   = act_reg;
        d_since = since_reg;
        d_start = start_reg;
        d_peak  = peak_reg;
        d_conf  = 1'b0;
        d_rep   = 1'b0;
        if (!d_act && !d_pend && above) begin
            d_pend  = 1'b1;
            d_since = now_reg;
        end
        if (d_pend && !d_act) begin
            if (above) begin
                if ((now_reg - d_since) >= cfg.confirm_ms) begin
                    d_act   = 1'b1;
                    d_start = d_since;
                    d_peak  = corr_reg;
                    d_conf  = 1'b1;
                end
            end else begin
                d_pend = 1'b0;
            end
        end
        d_dur = now_reg - d_start;
        if (d_act) begin
            if (corr_reg > d_peak) begin
                d_peak = corr_reg;
            end
            if ((dvd_reg < {16'd0, cfg.detrigger_ratio}) || (d_dur > cfg.max_event_ms)) begin
                d_rep = 1'b1;
            end
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            eidx_reg     <= E_BASE;
            baseline_reg <= '0;
            short_reg    <= '0;
            long_reg     <= sld_pkg::RST_MIN_LTA;
            peak_reg     <= '0;
            pend_reg     <= 1'b0;
            act_reg      <= 1'b0;
            since_reg    <= '0;
            start_reg    <= '0;
            last_reg     <= '0;
            err_reg      <= '0;
            ovf_reg      <= '0;
            conf_reg     <= 1'b0;
            rep_reg      <= 1'b0;
            fifo_reg     <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        now_reg      <= in_now;
                        ax_reg       <= in_x[15] ? 16'(-in_x) : in_x;
                        ay_reg       <= in_y[15] ? 16'(-in_y) : in_y;
                        az_reg       <= in_z[15] ? 16'(-in_z) : in_z;
                        conf_reg     <= 1'b0;
                        rep_reg      <= 1'b0;
                        fifo_reg     <= 1'b0;
                        rep_peak_reg <= '0;
                        rep_dur_reg  <= '0;
                        rep_time_reg <= '0;
                        cnt_reg      <= '0;
                        if (in_status == sld_pkg::ST_OVERFLOW) begin
                            fifo_reg <= 1'b1;
                            err_reg  <= '0;
                            if (ovf_reg != 16'hFFFF) begin
                                ovf_reg <= ovf_reg + 16'd1;
                            end
                            state_reg <= S_OUT;
                        end else if (in_status != sld_pkg::ST_VALID) begin
                            if (err_inc > {1'b0, ERROR_LIMIT}) begin
                                fifo_reg <= 1'b1;
                                err_reg  <= '0;
                            end else begin
                                err_reg <= err_inc[7:0];
                            end
                            state_reg <= S_OUT;
                        end else begin
                            err_reg   <= '0;
                            state_reg <= S_SQ;
                        end
                    end
                end
                // sum of squares, one axis a cycle
                S_SQ: begin
                    acc_reg <= mac_out;
                    if (cnt_reg == 5'd2) begin
                        cnt_reg   <= '0;
                        vsh_reg   <= {mac_out[31:0], 16'd0};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        state_reg <= S_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                // square root, two radicand bits a cycle
                S_SQRT: begin
                    vsh_reg  <= {vsh_reg[45:0], 2'b00};
                    rem_reg  <= alu_ge ? alu_diff[24:0] : alu_a[24:0];
                    root_reg <= {root_reg[22:0], alu_ge};
                    if (cnt_reg == 5'd23) begin
                        cnt_reg   <= '0;
                        state_reg <= S_SCALE;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_SCALE: begin
                    acc_reg   <= mac_out;
                    eidx_reg  <= E_BASE;
                    state_reg <= S_EA;
                end
                // average: alpha times new value
                S_EA: begin
                    if (eidx_reg == E_BASE) begin
                        mag_reg <= mag_sat;
                    end
                    acc_reg   <= mac_out;
                    state_reg <= S_EB;
                end
                // average: plus complement times old value, rounded
                S_EB: begin
                    acc_reg   <= mac_out;
                    state_reg <= S_EW;
                end
                S_EW: begin
                    case (eidx_reg)
                        E_BASE: begin
                            baseline_reg <= new_avg;
                            corr_reg     <= (mag_reg >= new_avg) ? mag_reg - new_avg
                                                                 : new_avg - mag_reg;
                            eidx_reg     <= E_SHORT;
                            state_reg    <= S_EA;
                        end
                        E_SHORT: begin
                            short_reg <= new_avg;
                            if (act_reg) begin
                                state_reg <= S_GATE;
                            end else begin
                                eidx_reg  <= E_LONG;
                                state_reg <= S_EA;
                            end
                        end
                        default: begin
                            long_reg  <= new_avg;
                            state_reg <= S_GATE;
                        end
                    endcase
                end
                // warm-up and cooldown check, divider set-up
                S_GATE: begin
                    dvd_reg <= {short_reg, 8'd0};
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (long_reg > cfg.min_lta_level) begin
                        lc_reg <= long_reg;
                    end else if (cfg.min_lta_level == '0) begin
                        lc_reg <= 24'd1;
                    end else begin
                        lc_reg <= cfg.min_lta_level;
                    end
                    if ((now_reg >= cfg.warmup_ms)
                        && (act_reg || ((now_reg - last_reg) >= cfg.cooldown_ms))) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                // restoring division, one quotient bit a cycle
                S_DIV: begin
                    rem_reg <= {1'b0, alu_ge ? alu_diff[23:0] : alu_a[23:0]};
                    dvd_reg <= {dvd_reg[30:0], alu_ge};
                    if (cnt_reg == 5'd31) begin
                        state_reg <= S_DET;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_DET: begin
                    conf_reg  <= d_conf;
                    since_reg <= d_since;
                    start_reg <= d_start;
                    if (d_rep) begin
                        rep_reg      <= 1'b1;
                        rep_peak_reg <= d_peak;
                        rep_dur_reg  <= d_dur;
                        rep_time_reg <= now_reg;
                        last_reg     <= now_reg;
                        act_reg      <= 1'b0;
                        pend_reg     <= 1'b0;
                        peak_reg     <= '0;
                    end else begin
                        act_reg  <= d_act;
                        pend_reg <= d_pend;
                        peak_reg <= d_peak;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    always_comb begin
        res.event_active       = act_reg;
        res.potential_pending  = pend_reg;
        res.event_confirmed    = conf_reg;
        res.report_valid       = rep_reg;
        res.report_peak        = rep_peak_reg;
        res.report_duration_ms = rep_dur_reg;
        res.report_time_ms     = rep_time_reg;
        res.fifo_reset         = fifo_reg;
        res.sta_level          = short_reg;
        res.lta_level          = long_reg;
        res.overflow_count     = ovf_reg;
    end

endmodule

// ===== rtl/sta_lta_event_detector_top.sv =====
// sta_lta_event_detector_top: stream wrapper, config registers and output register
// depends on sld_pkg, sld_core
//
// usage:
//  s_ channel carries one acceleration sample per transaction: status in s_tuser,
//  axes and millisecond time in s_tdata. m_ channel returns one result per sample.
//  cfg channel writes one tuning register per transaction (cfg_index, cfg_data);
//  cfg_ready is always high and registers should only be written while idle.
//  error and overflow samples skip the datapath: the core goes from idle straight to
//  its output state and the output register then drives m_tvalid. A valid sample
//  passes three squares, the 24-step square root, the scale and the averages (the
//  long term average is frozen while an event is active), then, after warm-up and
//  outside cooldown only, the 32-step ratio division; root and division share one
//  subtract/compare unit, squares, scale and averages the 16x24 multiply-accumulate.
//  throughput: one sample at a time; s_tready is low while a sample is worked on.
//  stall: the result sits in the output register while m_tready is low; the next
//  sample is taken and processed meanwhile, and waits at its end for the register.
//  reset: aresetn low for one clock clears all detector state, restores config
//  defaults and sets the long term average to the default lta floor.

module sta_lta_event_detector_top #(
    parameter logic [15:0] BASE_GAIN_Q16      = 16'(sld_pkg::BASE_GAIN_DEF),
    parameter logic [15:0] SHORT_ALPHA_Q16    = 16'(sld_pkg::SHORT_ALPHA_DEF),
    parameter logic [15:0] LONG_ALPHA_Q16     = 16'(sld_pkg::LONG_ALPHA_DEF),
    parameter logic [15:0] SCALE_Q8           = 16'(sld_pkg::SCALE_DEF),
    parameter logic [7:0]  ERROR_LIMIT        = 8'(sld_pkg::ERROR_LIMIT_DEF)
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // sample channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // accel_x, accel_y, accel_z, now_ms
    input  logic [1:0]   s_tuser,   // sample_status
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_active, potential_pending, event_confirmed, report_peak,
    // report_duration_ms, report_time_ms, fifo_reset, sta_level, lta_level,
    // overflow_count, zero pad
    output logic [159:0] m_tdata,
    output logic         m_tuser    // report_valid
);

    sld_pkg::cfg_t    cfg_reg;
    sld_pkg::result_t core_res, out_reg;
    logic             out_valid_reg;
    logic             core_valid, core_ready;

    // config register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ratio   <= sld_pkg::RST_TRIGGER;
            cfg_reg.detrigger_ratio <= sld_pkg::RST_DETRIGGER;
            cfg_reg.min_sta_level   <= sld_pkg::RST_MIN_STA;
            cfg_reg.min_lta_level   <= sld_pkg::RST_MIN_LTA;
            cfg_reg.confirm_ms      <= sld_pkg::RST_CONFIRM;
            cfg_reg.max_event_ms    <= sld_pkg::RST_MAX_EVENT;
            cfg_reg.cooldown_ms     <= sld_pkg::RST_COOLDOWN;
            cfg_reg.warmup_ms       <= sld_pkg::RST_WARMUP;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sld_pkg::REG_TRIGGER:   cfg_reg.trigger_ratio   <= cfg_data[15:0];
                sld_pkg::REG_DETRIGGER: cfg_reg.detrigger_ratio <= cfg_data[15:0];
                sld_pkg::REG_MIN_STA:   cfg_reg.min_sta_level   <= cfg_data[23:0];
                sld_pkg::REG_MIN_LTA:   cfg_reg.min_lta_level   <= cfg_data[23:0];
                sld_pkg::REG_CONFIRM:   cfg_reg.confirm_ms      <= cfg_data;
                sld_pkg::REG_MAX_EVENT: cfg_reg.max_event_ms    <= cfg_data;
                sld_pkg::REG_COOLDOWN:  cfg_reg.cooldown_ms     <= cfg_data;
                default:                cfg_reg.warmup_ms       <= cfg_data;
            endcase
        end
    end

    sld_core #(
        .BASE_GAIN      (BASE_GAIN_Q16),
        .SHORT_ALPHA    (SHORT_ALPHA_Q16),
        .LONG_ALPHA     (LONG_ALPHA_Q16),
        .SCALE          (SCALE_Q8),
        .ERROR_LIMIT    (ERROR_LIMIT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_status (s_tuser),
        .in_x      (s_tdata[15:0]),
        .in_y      (s_tdata[31:16]),
        .in_z      (s_tdata[47:32]),
        .in_now    (s_tdata[79:48]),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .res       (core_res)
    );

    // output register, loads when empty or being drained
    assign core_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_ready) begin
            out_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_ready && core_valid) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.report_valid;
    assign m_tdata  = {4'd0,
                       out_reg.overflow_count,
                       out_reg.lta_level,
                       out_reg.sta_level,
                       out_reg.fifo_reset,
                       out_reg.report_time_ms,
                       out_reg.report_duration_ms,
                       out_reg.report_peak,
                       out_reg.event_confirmed,
                       out_reg.potential_pending,
                       out_reg.event_active};

endmodule

// ===== rtl/sld_checker.sv =====
// sld_checker: port-level assertions on the detector's result channel
// depends on sta_lta_event_detector_top (bound to it below)

module sld_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic         m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // nothing offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an ended event is no longer active or pending
    a_report_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[0] && !m_tdata[1])
        else $error("report with event still active");

    // a confirmation is either active or ended in the same transaction
    a_confirm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[0] || m_tuser)
        else $error("confirmed event neither active nor reported");

    // report fields are zero without a report
    a_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[90:3] == '0)
        else $error("report fields set without report");

endmodule

bind sta_lta_event_detector_top sld_checker u_sld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/sta_lta_event_detector_top_tb.sv =====
// sta_lta_event_detector_top_tb: self-checking bench for the sta/lta event detector
// depends on sld_pkg and sta_lta_event_detector_top; a local detector model predicts
// every result, which is compared field by field against the m_ channel

module sta_lta_event_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // status codes the package leaves unnamed
    localparam logic [1:0] ST_READ_FAIL = 2'd2;
    localparam logic [1:0] ST_UNDEFINED = 2'd3;

    localparam logic [15:0] BASE_GAIN   = 16'd328;
    localparam logic [15:0] SHORT_GAIN  = 16'd1311;
    localparam logic [15:0] LONG_GAIN   = 16'd33;
    localparam logic [15:0] MAG_SCALE   = 16'd256;
    localparam int unsigned ERR_LIMIT   = 10;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;   // accel_x, accel_y, accel_z, now_ms
    logic [1:0]   s_tuser;   // sample_status
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // event_active .. overflow_count, zero pad
    logic         m_tuser;   // report_valid

    sta_lta_event_detector_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // detector model state
    sld_pkg::cfg_t det_cfg;
    logic [31:0] baseline_q, sta_q, lta_q;
    logic        pending_q, active_q;
    logic [31:0] pending_t0, event_t0, last_report_t;
    logic [23:0] peak_q;
    logic [7:0]  err_run_q;
    logic [15:0] ovf_total_q;

    sld_pkg::result_t pending_results[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    logic [31:0] clock_ms = 32'd0;

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] ema_step(logic [31:0] avg, logic [31:0] v,
                                             logic [15:0] a);
        longint unsigned s;
        s = longint'(a) * v + (64'd65536 - a) * avg + 64'd32768;
        return s[47:16];
    endfunction

    function automatic logic [31:0] mag_of(logic [15:0] v);
        return v[15] ? 32'h10000 - {16'h0, v} : {16'h0, v};
    endfunction

    // advance the model by one sample and return the result it predicts
    function automatic sld_pkg::result_t predict_sample(logic [1:0] st, logic [15:0] x,
                                                        logic [15:0] y, logic [15:0] z,
                                                        logic [31:0] now);
        sld_pkg::result_t r;
        longint unsigned sum, m;
        logic [31:0]     ax, ay, az, mag, corr, lc, dur;
        longint unsigned ratio;
        logic            above;
        r = '0;
        if (st == sld_pkg::ST_OVERFLOW) begin
            r.fifo_reset = 1'b1;
            err_run_q = '0;
            if (ovf_total_q != 16'hFFFF) ovf_total_q++;
        end else if (st != sld_pkg::ST_VALID) begin
            if (int'(err_run_q) + 1 > ERR_LIMIT) begin
                r.fifo_reset = 1'b1;
                err_run_q = '0;
            end else begin
                err_run_q++;
            end
        end else begin
            ax = mag_of(x);
            ay = mag_of(y);
            az = mag_of(z);
            sum = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
            m = (sqrt_floor(sum << 16) * MAG_SCALE) >> 8;
            mag = (m > 64'hFFFFFF) ? 32'hFFFFFF : m[31:0];
            err_run_q = '0;
            baseline_q = ema_step(baseline_q, mag, BASE_GAIN);
            corr = (mag >= baseline_q) ? mag - baseline_q : baseline_q - mag;
            sta_q = ema_step(sta_q, corr, SHORT_GAIN);
            if (!active_q) lta_q = ema_step(lta_q, corr, LONG_GAIN);
            if (now >= det_cfg.warmup_ms &&
                (active_q || (now - last_report_t) >= det_cfg.cooldown_ms)) begin
                lc = (lta_q > det_cfg.min_lta_level) ? lta_q : det_cfg.min_lta_level;
                if (lc == 0) lc = 1;
                ratio = ({32'h0, sta_q} << 8) / lc;
                above = ratio >= det_cfg.trigger_ratio && sta_q >= det_cfg.min_sta_level;
                // trigger, confirm and end may all fall on the same sample
                if (!active_q && !pending_q && above) begin
                    pending_q = 1'b1;
                    pending_t0 = now;
                end
                if (pending_q && !active_q) begin
                    if (above) begin
                        if ((now - pending_t0) >= det_cfg.confirm_ms) begin
                            active_q = 1'b1;
                            event_t0 = pending_t0;
                            peak_q = corr[23:0];
                            r.event_confirmed = 1'b1;
                        end
                    end else begin
                        pending_q = 1'b0;
                    end
                end
                if (active_q) begin
                    dur = now - event_t0;
                    if (corr > peak_q) peak_q = corr[23:0];
                    if (ratio < det_cfg.detrigger_ratio || dur > det_cfg.max_event_ms) begin
                        r.report_valid = 1'b1;
                        r.report_peak = peak_q;
                        r.report_duration_ms = dur;
                        r.report_time_ms = now;
                        last_report_t = now;
                        active_q = 1'b0;
                        pending_q = 1'b0;
                        peak_q = '0;
                    end
                end
            end
        end
        r.event_active = active_q;
        r.potential_pending = pending_q;
        r.sta_level = sta_q[23:0];
        r.lta_level = lta_q[23:0];
        r.overflow_count = ovf_total_q;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        sld_pkg::result_t got;
        sld_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_active       = m_tdata[0];
            got.potential_pending  = m_tdata[1];
            got.event_confirmed    = m_tdata[2];
            got.report_peak        = m_tdata[26:3];
            got.report_duration_ms = m_tdata[58:27];
            got.report_time_ms     = m_tdata[90:59];
            got.fifo_reset         = m_tdata[91];
            got.sta_level          = m_tdata[115:92];
            got.lta_level          = m_tdata[139:116];
            got.overflow_count     = m_tdata[155:140];
            got.report_valid       = m_tuser;
            if (pending_results.size() == 0) begin
                $error("result transaction with no prediction waiting");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("event_active", 32'(want.event_active),
                            32'(got.event_active));
                check_field("potential_pending", 32'(want.potential_pending),
                            32'(got.potential_pending));
                check_field("event_confirmed", 32'(want.event_confirmed),
                            32'(got.event_confirmed));
                check_field("report_valid", 32'(want.report_valid),
                            32'(got.report_valid));
                check_field("report_peak", 32'(want.report_peak), 32'(got.report_peak));
                check_field("report_duration_ms", want.report_duration_ms,
                            got.report_duration_ms);
                check_field("report_time_ms", want.report_time_ms, got.report_time_ms);
                check_field("fifo_reset", 32'(want.fifo_reset), 32'(got.fifo_reset));
                check_field("sta_level", 32'(want.sta_level), 32'(got.sta_level));
                check_field("lta_level", 32'(want.lta_level), 32'(got.lta_level));
                check_field("overflow_count", 32'(want.overflow_count),
                            32'(got.overflow_count));
                check_field("zero pad", 32'd0, 32'(m_tdata[159:156]));
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver backpressure in random bursts
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // one sample transaction, predicted when accepted
    task automatic send_sample(logic [1:0] st, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z, logic [31:0] now);
        if (tx_idle_en && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        else
            @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= st;
        s_tdata  <= {now, z, y, x};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_sample(st, x, y, z, now));
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sld_pkg::REG_TRIGGER:   det_cfg.trigger_ratio   = val[15:0];
            sld_pkg::REG_DETRIGGER: det_cfg.detrigger_ratio = val[15:0];
            sld_pkg::REG_MIN_STA:   det_cfg.min_sta_level   = val[23:0];
            sld_pkg::REG_MIN_LTA:   det_cfg.min_lta_level   = val[23:0];
            sld_pkg::REG_CONFIRM:   det_cfg.confirm_ms      = val;
            sld_pkg::REG_MAX_EVENT: det_cfg.max_event_ms    = val;
            sld_pkg::REG_COOLDOWN:  det_cfg.cooldown_ms     = val;
            sld_pkg::REG_WARMUP:    det_cfg.warmup_ms       = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] trig, logic [15:0] detrig, logic [23:0] min_sta,
                             logic [23:0] min_lta, logic [31:0] confirm,
                             logic [31:0] max_ev, logic [31:0] cool, logic [31:0] warm);
        write_reg(sld_pkg::REG_TRIGGER, {16'h0, trig});
        write_reg(sld_pkg::REG_DETRIGGER, {16'h0, detrig});
        write_reg(sld_pkg::REG_MIN_STA, {8'h0, min_sta});
        write_reg(sld_pkg::REG_MIN_LTA, {8'h0, min_lta});
        write_reg(sld_pkg::REG_CONFIRM, confirm);
        write_reg(sld_pkg::REG_MAX_EVENT, max_ev);
        write_reg(sld_pkg::REG_COOLDOWN, cool);
        write_reg(sld_pkg::REG_WARMUP, warm);
    endtask

    function automatic logic [15:0] rand_axis(int unsigned amp);
        int v;
        v = int'($urandom_range(0, 2 * amp)) - int'(amp);
        return v[15:0];
    endfunction

    task automatic send_valid(int unsigned amp, int unsigned step_max);
        clock_ms += $urandom_range(1, step_max);
        send_sample(sld_pkg::ST_VALID, rand_axis(amp), rand_axis(amp), rand_axis(amp),
                    clock_ms);
    endtask

    // field extremes, every status, the error run limit and a one-sample event
    task automatic test_directed();
        send_sample(sld_pkg::ST_VALID, 16'h0000, 16'h0000, 16'h0000, 32'd0);
        send_sample(sld_pkg::ST_VALID, 16'h8000, 16'h8000, 16'h8000, 32'd100);
        send_sample(sld_pkg::ST_VALID, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd200);
        send_sample(sld_pkg::ST_VALID, 16'h8000, 16'h7FFF, 16'h0001, 32'd300);
        send_sample(sld_pkg::ST_OVERFLOW, 16'h7FFF, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF);
        send_sample(ST_UNDEFINED, 16'h1234, 16'h0, 16'h0, 32'd400);
        send_sample(sld_pkg::ST_VALID, 16'hFFFF, 16'h0001, 16'h8000, 32'd500);
        // read failures run past the limit and then the run restarts
        repeat (ERR_LIMIT + 2) send_sample(ST_READ_FAIL, 16'h0, 16'h0, 16'h0, 32'd600);
        send_sample(sld_pkg::ST_VALID, 16'h0100, 16'h0, 16'h0, 32'd700);
        wait_drained();
        // zero lta floor, instant trigger, confirm and end on one sample, time wrap
        write_all(16'h0000, 16'hFFFF, 24'h0, 24'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_sample(sld_pkg::ST_VALID, 16'h7FFF, 16'h0, 16'h0, 32'hFFFF_FFF0);
        send_sample(sld_pkg::ST_VALID, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF);
        send_sample(sld_pkg::ST_VALID, 16'h4000, 16'h4000, 16'h0, 32'h0000_0005);
        wait_drained();
    endtask

    // all registers at their low and high extremes
    task automatic test_config_extremes();
        write_all(16'h0, 16'h0, 24'h0, 24'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        repeat (40) send_valid($urandom_range(0, 32767), 50);
        wait_drained();
        write_all(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (40) send_valid($urandom_range(0, 32767), 50);
        wait_drained();
    endtask

    // quiet stretches and shaking bursts under settings that let events occur
    task automatic test_events(int unsigned n_phases, int unsigned per_phase);
        int unsigned sent;
        int unsigned seg;
        int unsigned amp;
        bit          burst;
        for (int p = 0; p < n_phases; p++) begin
            write_all(16'($urandom_range(128, 1024)), 16'($urandom_range(64, 512)),
                      24'($urandom_range(0, 4000)), 24'($urandom_range(1, 2000)),
                      $urandom_range(0, 300), $urandom_range(100, 4000),
                      $urandom_range(0, 1500), clock_ms + $urandom_range(0, 500));
            sent = 0;
            burst = 1'b0;
            while (sent < per_phase) begin
                seg = burst ? $urandom_range(5, 60) : $urandom_range(10, 40);
                amp = burst ? $urandom_range(1000, 32767) : $urandom_range(0, 64);
                for (int i = 0; i < seg && sent < per_phase; i++) begin
                    if ($urandom_range(0, 24) == 0)
                        send_sample(2'($urandom_range(1, 3)), rand_axis(32767),
                                    rand_axis(32767), rand_axis(32767), $urandom());
                    else
                        send_valid(amp, 40);
                    sent++;
                end
                burst = !burst;
            end
            // hold the sender until the block has returned every result
            if (p == 1) wait_drained();
            wait_drained();
        end
    endtask

    // random status, axes and time
    task automatic test_noise(int unsigned n);
        write_all(16'($urandom()), 16'($urandom()), 24'($urandom()), 24'($urandom()),
                  $urandom_range(0, 2000), $urandom(), $urandom_range(0, 5000),
                  $urandom());
        repeat (n) begin
            clock_ms = ($urandom_range(0, 3) == 0) ? $urandom() : clock_ms + 10;
            send_sample(2'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), clock_ms);
        end
        wait_drained();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate(int unsigned n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (n) send_valid($urandom_range(0, 32767), 30);
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        det_cfg = '{sld_pkg::RST_TRIGGER, sld_pkg::RST_DETRIGGER, sld_pkg::RST_MIN_STA,
                    sld_pkg::RST_MIN_LTA, sld_pkg::RST_CONFIRM, sld_pkg::RST_MAX_EVENT,
                    sld_pkg::RST_COOLDOWN, sld_pkg::RST_WARMUP};
        baseline_q = '0;
        sta_q = '0;
        lta_q = {8'h0, sld_pkg::RST_MIN_LTA};
        pending_q = 1'b0;
        active_q = 1'b0;
        pending_t0 = '0;
        event_t0 = '0;
        last_report_t = '0;
        peak_q = '0;
        err_run_q = '0;
        ovf_total_q = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_config_extremes();
        test_events(5, 120);
        test_noise(150);
        test_full_rate(60);

        wait_drained();
        repeat (100) @(negedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
